### hdl/pfrw_pkg.sv
// Shared types and constants for the packed framebuffer writer.
// Holds the item structs, function codes, register indexes and nibble masks.
// No dependencies.
package pfrw_pkg;

    // function codes of an input item
    localparam logic [1:0] FUNC_DRAW = 2'd0;
    localparam logic [1:0] FUNC_FILL = 2'd1;
    localparam logic [1:0] FUNC_READ = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_ROTATION = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLANK_COLOR = 4'd1;

    localparam logic [1:0] ROTATION_RESET = 2'd0;
    localparam logic [3:0] BLANK_COLOR_RESET = 4'd1;

    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_CLIPPED = 1'b1;

    localparam logic [7:0] NIB_LO_MASK = 8'h0F;
    localparam logic [7:0] NIB_HI_MASK = 8'hF0;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [3:0]         color;
    } t_in_item;

    typedef struct packed {
        logic       status;
        logic [7:0] data_byte;
        logic       ic_select;
        logic       frame_end;
    } t_out_item;

    // result of mapping a draw coordinate onto the panel
    typedef struct packed {
        logic clipped;
        logic odd_x;
    } t_draw_flags;

endpackage

### hdl/pfrw_coord_map.sv
// Rotation, clipping and byte addressing of a logical draw coordinate.
// Depends on pfrw_pkg for t_draw_flags.
module pfrw_coord_map
    import pfrw_pkg::*;
#(
    parameter int PANEL_WIDTH = 256,
    parameter int PANEL_HEIGHT = 128,
    localparam int StoreBytes = (PANEL_WIDTH * PANEL_HEIGHT + 1) / 2,
    localparam int AddrW = $clog2(StoreBytes)
) (
    input  logic [1:0]         i_rotation,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    output t_draw_flags        o_flags,
    output logic [AddrW-1:0]   o_addr
);

    localparam int LinW = $clog2(PANEL_WIDTH * PANEL_HEIGHT);
    localparam logic signed [17:0] XMax = 18'(PANEL_WIDTH - 1);
    localparam logic signed [17:0] YMax = 18'(PANEL_HEIGHT - 1);

    logic signed [17:0] sx, sy, px, py;
    logic [LinW-1:0]    lin;

    assign sx = 18'(i_pos_x);
    assign sy = 18'(i_pos_y);

    always_comb begin
        unique case (i_rotation)
            2'd1: begin
                px = XMax - sy;
                py = sx;
            end
            2'd2: begin
                px = XMax - sx;
                py = YMax - sy;
            end
            2'd3: begin
                px = sy;
                py = YMax - sx;
            end
            default: begin
                px = sx;
                py = sy;
            end
        endcase
    end

    // linear pixel index; the byte holds two pixels
    assign lin = LinW'(py[15:0]) * LinW'(PANEL_WIDTH) + LinW'(px[15:0]);

    assign o_flags.clipped = (px < 0) || (px > XMax) || (py < 0) || (py > YMax);
    assign o_flags.odd_x = px[0];
    assign o_addr = AddrW'(lin >> 1);

endmodule

### hdl/packed_framebuffer_rotated_writer_unit.sv
// Top level of the nibble-packed framebuffer with rotated drawing and readout.
// Depends on pfrw_pkg and pfrw_coord_map; holds the frame store memory.
//
// A landed draw or a read holds the input for the memory read, then the write back or
// result in S_DRAW or S_READ, which registers the result; a clipped draw or an unused
// function code has its result registered at acceptance. A fill sweeps one byte a
// cycle over the whole store. A result that finds the output register occupied is
// parked and stalls input until it drains.
// Reset is synchronous: after it the store is swept with the blank colour while input is
// stalled; configuration writes are taken throughout.
module packed_framebuffer_rotated_writer_unit
    import pfrw_pkg::*;
#(
    parameter int PANEL_WIDTH = 256,
    parameter int PANEL_HEIGHT = 128
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int StoreBytes = (PANEL_WIDTH * PANEL_HEIGHT + 1) / 2;
    localparam int AddrW = $clog2(StoreBytes);
    localparam int RowBytes = PANEL_WIDTH / 2;
    localparam int HalfBytes = PANEL_WIDTH / 4;
    localparam int ColW = (HalfBytes > 1) ? $clog2(HalfBytes) : 1;
    localparam int RowW = (PANEL_HEIGHT > 1) ? $clog2(PANEL_HEIGHT) : 1;
    localparam logic [AddrW-1:0] LastAddr = AddrW'(StoreBytes - 1);
    localparam logic [ColW-1:0] LastCol = ColW'(HalfBytes - 1);
    localparam logic [RowW-1:0] LastRow = RowW'(PANEL_HEIGHT - 1);

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_DRAW,
        S_READ,
        S_HOLD
    } t_state;

    t_state r_state, n_state;

    logic                 r_out_valid, n_out_valid;
    t_out_item            r_out, n_out;
    t_out_item            r_hold, n_hold;
    logic [AddrW-1:0]     r_sweep_addr, n_sweep_addr;
    logic [7:0]           r_sweep_byte, n_sweep_byte;
    logic                 r_sweep_item, n_sweep_item;
    logic [1:0]           r_rotation, n_rotation;
    logic                 r_rd_sec, n_rd_sec;
    logic [RowW-1:0]      r_rd_row, n_rd_row;
    logic [ColW-1:0]      r_rd_col, n_rd_col;
    logic [AddrW-1:0]     r_rd_base, n_rd_base;
    logic                 r_rd_ic, n_rd_ic;
    logic                 r_rd_end, n_rd_end;
    logic [AddrW-1:0]     r_draw_addr, n_draw_addr;
    logic                 r_draw_odd, n_draw_odd;
    logic [3:0]           r_draw_color, n_draw_color;

    logic [7:0]           r_mem [StoreBytes];
    logic [7:0]           r_mem_q;
    logic                 mem_we;
    logic [AddrW-1:0]     mem_waddr;
    logic [7:0]           mem_wdata;
    logic [AddrW-1:0]     mem_raddr;

    t_draw_flags          map_flags;
    logic [AddrW-1:0]     map_addr;
    logic                 in_accept;
    logic                 out_free;
    logic                 res_valid;
    t_out_item            res;

    pfrw_coord_map #(
        .PANEL_WIDTH (PANEL_WIDTH),
        .PANEL_HEIGHT(PANEL_HEIGHT)
    ) u_coord_map (
        .i_rotation(r_rotation),
        .i_pos_x   (i_in_item.pos_x),
        .i_pos_y   (i_in_item.pos_y),
        .o_flags   (map_flags),
        .o_addr    (map_addr)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item = r_out;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_state = r_state;
        n_hold = r_hold;
        n_sweep_addr = r_sweep_addr;
        n_sweep_byte = r_sweep_byte;
        n_sweep_item = r_sweep_item;
        n_rotation = r_rotation;
        n_rd_sec = r_rd_sec;
        n_rd_row = r_rd_row;
        n_rd_col = r_rd_col;
        n_rd_base = r_rd_base;
        n_rd_ic = r_rd_ic;
        n_rd_end = r_rd_end;
        n_draw_addr = r_draw_addr;
        n_draw_odd = r_draw_odd;
        n_draw_color = r_draw_color;
        mem_we = 1'b0;
        mem_waddr = r_sweep_addr;
        mem_wdata = r_sweep_byte;
        mem_raddr = map_addr;
        res_valid = 1'b0;
        res = '0;

        // blank colour only matters at reset, which restores it; drop the write
        if (i_cfg_valid && (i_cfg_index == REG_ROTATION)) begin
            n_rotation = i_cfg_data[1:0];
        end

        unique case (r_state)
            S_SWEEP: begin
                mem_we = 1'b1;
                n_sweep_addr = r_sweep_addr + AddrW'(1);
                if (r_sweep_addr == LastAddr) begin
                    n_state = S_IDLE;
                    res_valid = r_sweep_item;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    unique case (i_in_item.func)
                        FUNC_DRAW: begin
                            if (map_flags.clipped) begin
                                res_valid = 1'b1;
                                res.status = STATUS_CLIPPED;
                            end else begin
                                n_draw_addr = map_addr;
                                n_draw_odd = map_flags.odd_x;
                                n_draw_color = i_in_item.color;
                                n_state = S_DRAW;
                            end
                        end
                        FUNC_FILL: begin
                            n_sweep_addr = '0;
                            n_sweep_byte = {i_in_item.color, i_in_item.color};
                            n_sweep_item = 1'b1;
                            n_state = S_SWEEP;
                        end
                        FUNC_READ: begin
                            mem_raddr = r_rd_base + AddrW'(r_rd_col);
                            n_rd_ic = r_rd_sec;
                            n_rd_end = 1'b0;
                            n_state = S_READ;
                            if (r_rd_col == LastCol) begin
                                n_rd_col = '0;
                                if (r_rd_row == LastRow) begin
                                    n_rd_row = '0;
                                    n_rd_sec = !r_rd_sec;
                                    n_rd_end = r_rd_sec;
                                    n_rd_base = r_rd_sec ? '0 : AddrW'(HalfBytes);
                                end else begin
                                    n_rd_row = r_rd_row + RowW'(1);
                                    n_rd_base = r_rd_base + AddrW'(RowBytes);
                                end
                            end else begin
                                n_rd_col = r_rd_col + ColW'(1);
                            end
                        end
                        default: begin
                            res_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_DRAW: begin
                mem_we = 1'b1;
                mem_waddr = r_draw_addr;
                mem_wdata = r_draw_odd ? ((r_mem_q & NIB_HI_MASK) | {4'h0, r_draw_color})
                                       : ((r_mem_q & NIB_LO_MASK) | {r_draw_color, 4'h0});
                res_valid = 1'b1;
                res.status = STATUS_DONE;
            end
            S_READ: begin
                res_valid = 1'b1;
                res.data_byte = r_mem_q;
                res.ic_select = r_rd_ic;
                res.frame_end = r_rd_end;
            end
            S_HOLD: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // park the result if the output register is still occupied
        if (res_valid) begin
            n_hold = res;
            n_state = out_free ? S_IDLE : S_HOLD;
        end

        n_out_valid = r_out_valid && i_out_stall;
        n_out = r_out;
        if (res_valid && out_free) begin
            n_out_valid = 1'b1;
            n_out = res;
        end else if ((r_state == S_HOLD) && out_free) begin
            n_out_valid = 1'b1;
            n_out = r_hold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
            r_out_valid <= 1'b0;
            r_sweep_addr <= '0;
            r_sweep_byte <= {BLANK_COLOR_RESET, BLANK_COLOR_RESET};
            r_sweep_item <= 1'b0;
            r_rotation <= ROTATION_RESET;
            r_rd_sec <= 1'b0;
            r_rd_row <= '0;
            r_rd_col <= '0;
            r_rd_base <= '0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
            r_sweep_addr <= n_sweep_addr;
            r_sweep_byte <= n_sweep_byte;
            r_sweep_item <= n_sweep_item;
            r_rotation <= n_rotation;
            r_rd_sec <= n_rd_sec;
            r_rd_row <= n_rd_row;
            r_rd_col <= n_rd_col;
            r_rd_base <= n_rd_base;
        end
        r_out <= n_out;
        r_hold <= n_hold;
        r_rd_ic <= n_rd_ic;
        r_rd_end <= n_rd_end;
        r_draw_addr <= n_draw_addr;
        r_draw_odd <= n_draw_odd;
        r_draw_color <= n_draw_color;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_mem_q <= r_mem[mem_raddr];
    end

    a_draw_writes_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && (i_in_item.func == FUNC_DRAW) && !map_flags.clipped |=> mem_we)
        else $error("unclipped draw did not write back");

    a_frame_end_on_right: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.frame_end |-> r_out.ic_select)
        else $error("frame end flagged outside driver 1 section");

    a_read_base_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_row == '0) && (r_rd_col == '0) |->
            (r_rd_base == (r_rd_sec ? AddrW'(HalfBytes) : '0)))
        else $error("readout base out of step with section");

    a_no_write_while_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) || (r_state == S_HOLD) || (r_state == S_READ) |-> !mem_we)
        else $error("store written outside a draw or sweep");

    a_result_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HOLD) && i_out_stall && r_out_valid |=> (r_state == S_HOLD))
        else $error("held result released while output register occupied");

endmodule
